### hdl/rfo_pkg.sv
// Package for the ring FIFO with overwrite: request and response payload
// types, opcode codes, register indexes and default sizes.
// No dependencies.
package rfo_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int ITEM_BITS_DEFAULT = 32;

   // Fixed field widths of the request and response payloads.
   localparam int DATA_BITS  = 32;
   localparam int POS_BITS   = 4;
   localparam int LEVEL_BITS = 5;

   // Configuration port.
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEPTH_IN_USE     = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERWRITE_ENABLE = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [DATA_BITS-1:0]   write_data;
      logic [POS_BITS-1:0]    position;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic [DATA_BITS-1:0]   read_data;
      logic [LEVEL_BITS-1:0]  fill_level;
      logic                   is_empty;
      logic                   is_full;
      logic [LEVEL_BITS-1:0]  space_left;
   } rsp_type;

   // Memory access strobes from the controller to the item store.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // Registered outcome of one request, less the read data that the
   // item store delivers in the same cycle.
   typedef struct packed {
      logic                   ok;
      logic                   rd_flag;
      logic [LEVEL_BITS-1:0]  fill_level;
      logic                   is_empty;
      logic                   is_full;
      logic [LEVEL_BITS-1:0]  space_left;
   } stat_type;

endpackage

### hdl/rfo_store.sv
// Item store of the ring FIFO: a single-port synchronous memory with a
// registered read port.
// Depends on rfo_pkg.
module rfo_store
   import rfo_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = ITEM_BITS_DEFAULT,
   parameter int PTR_BITS  = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  mem_ctl_type          mem_ctl,
   input  logic [PTR_BITS-1:0]  mem_addr,
   input  logic [WORD_BITS-1:0] mem_wdata,
   output logic [WORD_BITS-1:0] mem_rdata
);

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= mem_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

### hdl/rfo_ctrl.sv
// Controller of the ring FIFO: configuration registers, head and tail
// pointers, entry count, memory address selection and response status.
// Depends on rfo_pkg.
module rfo_ctrl
   import rfo_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = ITEM_BITS_DEFAULT,
   parameter int PTR_BITS  = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  req_type                  req_data,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output mem_ctl_type              mem_ctl,
   output logic [PTR_BITS-1:0]      mem_addr,
   output logic [WORD_BITS-1:0]     mem_wdata,
   output logic                     stat_valid,
   output stat_type                 stat
);

   // The depth register can name at most 31 entries.
   localparam logic [LEVEL_BITS-1:0] DEPTH_CAP = LEVEL_BITS'(DEPTH > 31 ? 31 : DEPTH);
   localparam int SUM_BITS = (PTR_BITS > LEVEL_BITS ? PTR_BITS : LEVEL_BITS) + 1;

   logic [LEVEL_BITS-1:0] depth_ff;
   logic                  overwrite_ff;
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [LEVEL_BITS-1:0] count_ff, count_in;
   logic                  stat_valid_ff;
   stat_type              stat_ff, stat_in;
   logic [LEVEL_BITS-1:0] depth_eff;
   logic [SUM_BITS-1:0]   peek_sum;

   // Step a pointer by one, wrapping at the effective depth.
   function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] p,
                                                   input logic [LEVEL_BITS-1:0] d);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(p) + SUM_BITS'(1);
      if (s >= SUM_BITS'(d)) begin
         s = s - SUM_BITS'(d);
      end
      return PTR_BITS'(s);
   endfunction

   always_comb begin
      if (depth_ff == '0) begin
         depth_eff = LEVEL_BITS'(1);
      end else if (depth_ff > DEPTH_CAP) begin
         depth_eff = DEPTH_CAP;
      end else begin
         depth_eff = depth_ff;
      end
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_addr      = head_ff;
      mem_wdata     = WORD_BITS'(req_data.write_data);
      stat_in.ok      = 1'b0;
      stat_in.rd_flag = 1'b0;
      peek_sum = SUM_BITS'(head_ff) + SUM_BITS'(req_data.position);
      if (peek_sum >= SUM_BITS'(depth_eff)) begin
         peek_sum = peek_sum - SUM_BITS'(depth_eff);
      end

      unique case (req_data.opcode)
         OP_WRITE: begin
            if (count_ff < depth_eff || overwrite_ff) begin
               mem_ctl.wr_en = accept;
               mem_addr      = tail_ff;
               tail_in       = advance(tail_ff, depth_eff);
               // A write into a full queue drops the oldest entry.
               if (count_ff >= depth_eff) begin
                  head_in = tail_in;
               end else begin
                  count_in = count_ff + LEVEL_BITS'(1);
               end
               stat_in.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (count_ff != '0) begin
               mem_ctl.rd_en   = accept;
               mem_addr        = head_ff;
               head_in         = advance(head_ff, depth_eff);
               count_in        = count_ff - LEVEL_BITS'(1);
               stat_in.ok      = 1'b1;
               stat_in.rd_flag = 1'b1;
            end
         end
         OP_PEEK: begin
            if (LEVEL_BITS'(req_data.position) < count_ff) begin
               mem_ctl.rd_en   = accept;
               mem_addr        = PTR_BITS'(peek_sum);
               stat_in.ok      = 1'b1;
               stat_in.rd_flag = 1'b1;
            end
         end
         OP_CLEAR: begin
            head_in    = '0;
            tail_in    = '0;
            count_in   = '0;
            stat_in.ok = 1'b1;
         end
         default: begin
            stat_in.ok = 1'b0;
         end
      endcase

      stat_in.fill_level = count_in;
      stat_in.is_empty   = (count_in == '0);
      stat_in.is_full    = (count_in == depth_eff);
      stat_in.space_left = depth_eff - count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= DEPTH_CAP;
         overwrite_ff  <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         stat_valid_ff <= 1'b0;
      end else begin
         stat_valid_ff <= accept;
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (csr_we) begin
            if (csr_index == CSR_DEPTH_IN_USE) begin
               // A new depth empties the queue so the pointers stay in range.
               depth_ff <= csr_wdata;
               head_ff  <= '0;
               tail_ff  <= '0;
               count_ff <= '0;
            end else if (csr_index == CSR_OVERWRITE_ENABLE) begin
               overwrite_ff <= csr_wdata[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stat_ff <= stat_in;
      end
   end

   assign stat_valid = stat_valid_ff;
   assign stat       = stat_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= depth_eff)
      else $error("entry count exceeds the depth in use");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (SUM_BITS'(head_ff) < SUM_BITS'(depth_eff)) &&
      (SUM_BITS'(tail_ff) < SUM_BITS'(depth_eff)))
      else $error("pointer beyond the depth in use");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == depth_eff) |-> head_ff == tail_ff)
      else $error("pointers disagree with an empty or full queue");

   a_one_port_use: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("store read and written in the same cycle");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> stat_valid_ff)
      else $error("accepted request produced no response");

endmodule

### hdl/ring_fifo_with_overwrite.sv
// Ring FIFO with overwrite: top level. A request accepted at one edge
// has its response strobed in the next cycle. One request may be taken
// every cycle (busy stays low); the response waits on the registered read
// of the single-port item store. The receiver cannot stall.
// Synchronous reset empties the queue, sets the depth to its maximum and
// turns overwrite off; store contents are left as they are.
module ring_fifo_with_overwrite
   import rfo_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // Items wider than the data field are never filled past it, so the
   // store keeps only the bits that can be written.
   localparam int WORD_BITS = ITEM_BITS < DATA_BITS ? ITEM_BITS : DATA_BITS;
   localparam int PTR_BITS  = $clog2(DEPTH);

   logic                 accept;
   mem_ctl_type          mem_ctl;
   logic [PTR_BITS-1:0]  mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] mem_rdata;
   logic                 stat_valid;
   stat_type             stat;

   // Each request uses the store port only while it is taken, and no two requests
   // ever touch the store port in the same cycle, so the block never
   // holds off the requester.
   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   rfo_ctrl #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS),
      .PTR_BITS  (PTR_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .stat_valid (stat_valid),
      .stat       (stat)
   );

   // A write lands in the store at the accepting edge; a read or peek of the
   // same entry in the next request is taken at a later edge and so sees the
   // new item without any forwarding.
   rfo_store #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS),
      .PTR_BITS  (PTR_BITS)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // The response joins the registered status with the store's read port.
   // Read data is forced to zero for writes, clears and refused requests.
   always_comb begin
      rsp_strobe          = stat_valid;
      rsp_data.ok         = stat.ok;
      rsp_data.read_data  = stat.rd_flag ? DATA_BITS'(mem_rdata) : '0;
      rsp_data.fill_level = stat.fill_level;
      rsp_data.is_empty   = stat.is_empty;
      rsp_data.is_full    = stat.is_full;
      rsp_data.space_left = stat.space_left;
   end

endmodule

### tb/ring_fifo_with_overwrite_tb.sv
// Self-checking testbench for the ring FIFO with overwrite: a clocked driver
// feeds requests from a queue, a clocked monitor predicts and checks responses.
// Depends on rfo_pkg and ring_fifo_with_overwrite.
module ring_fifo_with_overwrite_tb;
   import rfo_pkg::*;

   // The response for a request accepted at one edge is strobed in the
   // following cycle; wait_drained waits past it to cover any tail.
   localparam int LATENCY     = 1;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 40;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 73;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_start = 1'b0;
   logic                     busy;
   req_type                  req_data = '0;
   logic                     rsp_strobe;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_DEPTH_IN_USE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Requests waiting to be offered, and responses predicted but not yet seen.
   req_type pending_requests[$];
   rsp_type expected_responses[$];

   // Percentage of cycles in which the driver holds back a ready request.
   int unsigned idle_percent = 0;
   int unsigned error_count  = 0;
   int unsigned quiet_cycles = 0;

   // Shadow copy of the FIFO and its two registers.
   logic [DATA_BITS-1:0] shadow_store [DEPTH_DEFAULT];
   int unsigned          shadow_head;
   int unsigned          shadow_tail;
   int unsigned          shadow_count;
   logic [4:0]           shadow_depth_reg;
   logic                 shadow_overwrite;

   ring_fifo_with_overwrite dut (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A depth register of zero behaves as one entry, and anything above the
   // store size behaves as the full store.
   function automatic int unsigned clamp_depth(logic [4:0] value);
      if (value == 5'd0) begin
         return 1;
      end
      if (value > DEPTH_DEFAULT) begin
         return DEPTH_DEFAULT;
      end
      return 32'(value);
   endfunction

   function automatic int unsigned next_slot(int unsigned slot, int unsigned depth);
      return (slot + 1 >= depth) ? 0 : slot + 1;
   endfunction

   function automatic void shadow_empty();
      shadow_head  = 0;
      shadow_tail  = 0;
      shadow_count = 0;
   endfunction

   // Reset empties the queue and restores the register defaults. The store
   // contents survive, which is harmless because only entries written since
   // the last clear can ever be read.
   function automatic void shadow_reset();
      shadow_empty();
      shadow_depth_reg = 5'(DEPTH_DEFAULT);
      shadow_overwrite = 1'b0;
   endfunction

   // A depth write always clears the queue so that the pointers fit the new
   // depth; the overwrite register only looks at its low bit.
   function automatic void apply_register(logic [CSR_IDX_BITS-1:0] index,
                                          logic [CSR_DATA_BITS-1:0] value);
      if (index == CSR_DEPTH_IN_USE) begin
         shadow_depth_reg = value;
         shadow_empty();
      end else if (index == CSR_OVERWRITE_ENABLE) begin
         shadow_overwrite = value[0];
      end
   endfunction

   // Applies one request to the shadow FIFO and returns the response that
   // the block must give for it. Refused operations leave the state alone
   // and answer with ok low and zero data.
   function automatic rsp_type fifo_apply(req_type rq);
      rsp_type     rs;
      int unsigned depth;
      int unsigned slot;
      depth = clamp_depth(shadow_depth_reg);
      rs = '0;
      case (rq.opcode)
         OP_WRITE: begin
            if (shadow_count < depth || shadow_overwrite) begin
               shadow_store[shadow_tail] = rq.write_data;
               shadow_tail = next_slot(shadow_tail, depth);
               // When full, the oldest entry has just been replaced, so the
               // head moves along with the tail.
               if (shadow_count >= depth) begin
                  shadow_head = shadow_tail;
               end else begin
                  shadow_count++;
               end
               rs.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (shadow_count != 0) begin
               rs.read_data = shadow_store[shadow_head];
               shadow_head = next_slot(shadow_head, depth);
               shadow_count--;
               rs.ok = 1'b1;
            end
         end
         OP_PEEK: begin
            if (rq.position < shadow_count) begin
               slot = shadow_head + rq.position;
               if (slot >= depth) begin
                  slot -= depth;
               end
               rs.read_data = shadow_store[slot];
               rs.ok = 1'b1;
            end
         end
         default: begin
            shadow_empty();
            rs.ok = 1'b1;
         end
      endcase
      rs.fill_level = LEVEL_BITS'(shadow_count);
      rs.is_empty   = (shadow_count == 0);
      rs.is_full    = (shadow_count == depth);
      rs.space_left = LEVEL_BITS'(depth - shadow_count);
      return rs;
   endfunction

   // Every failure lands here. Printing stops after a while so that a badly
   // broken block cannot flood the log, but the count keeps going.
   task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      end
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_error(name, got, want);
      end
   endtask

   // Driver. A new request is offered only once the one on the ports has
   // been taken (or none was up). While a request is up and busy is high it
   // is simply held. Random holds come from idle_percent.
   always @(posedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else if (!req_start || !busy) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= idle_percent) begin
            req_start <= 1'b1;
            req_data  <= pending_requests.pop_front();
         end else begin
            req_start <= 1'b0;
         end
      end
   end

   // Monitor. Within one edge the response is checked first, then the
   // request taken at this edge is predicted, so the order of the always
   // blocks never matters. Register writes are mirrored here as well.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_reset();
      end else begin
         if (rsp_strobe) begin
            if (expected_responses.size() == 0) begin
               report_error("response with no request outstanding",
                            rsp_data.read_data, 32'd0);
            end else begin
               want = expected_responses.pop_front();
               check_field("ok",         32'(rsp_data.ok),         32'(want.ok));
               check_field("read_data",  rsp_data.read_data,       want.read_data);
               check_field("fill_level", 32'(rsp_data.fill_level), 32'(want.fill_level));
               check_field("is_empty",   32'(rsp_data.is_empty),   32'(want.is_empty));
               check_field("is_full",    32'(rsp_data.is_full),    32'(want.is_full));
               check_field("space_left", 32'(rsp_data.space_left), 32'(want.space_left));
            end
         end
         if (req_start && !busy) begin
            expected_responses.push_back(fifo_apply(req_data));
         end
         if (csr_we) begin
            apply_register(csr_index, csr_wdata);
         end
      end
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_strobe || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_op(opcode_type op, logic [31:0] value,
                                       logic [3:0] pos);
      req_type rq;
      rq.opcode     = op;
      rq.write_data = value;
      rq.position   = pos;
      return rq;
   endfunction

   // Random request. A filling mix pushes the queue up to full (and into
   // overwrite), a draining mix pulls it back down to empty. Peeks mostly
   // aim inside the current depth so that many of them hit.
   function automatic req_type make_request(bit filling, int unsigned depth);
      req_type     rq;
      int unsigned roll;
      int unsigned pick;
      roll = $urandom_range(99);
      pick = $urandom_range(7);
      rq.write_data = (pick == 0) ? 32'h0000_0000 :
                      (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      rq.position   = POS_BITS'($urandom_range(1) ? $urandom_range(depth - 1)
                                                  : $urandom_range(15));
      if (roll < (filling ? 60 : 20)) begin
         rq.opcode = OP_WRITE;
      end else if (roll < 75) begin
         rq.opcode = OP_READ;
      end else if (roll < 97) begin
         rq.opcode = OP_PEEK;
      end else begin
         rq.opcode = OP_CLEAR;
      end
      return rq;
   endfunction

   // Holds off until every queued request has gone out and every response
   // has come back, then lets the pipeline settle.
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_start || expected_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   // Writes both registers on consecutive edges. The enable stays high
   // across the pair and drops once at the end.
   task automatic write_settings(logic [4:0] depth_value, logic [4:0] overwrite_value);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEPTH_IN_USE;
      csr_wdata <= depth_value;
      @(posedge clock);
      csr_index <= CSR_OVERWRITE_ENABLE;
      csr_wdata <= overwrite_value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [4:0]  depth_list [PHASES];
      logic        overwrite_list [PHASES];
      int unsigned idle_list [PHASES];
      int unsigned depth;
      bit          filling;

      // Depths cover the clamped extremes (0 and 31) as well as 1, 2 and
      // the full store; the idle levels repeat none, heavy and light.
      depth_list     = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd2, 5'd17, 5'd9, 5'd16, 5'd3};
      overwrite_list = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      idle_list      = '{0, 49, 14, 0, 49, 14, 0, 49, 14, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Depth zero acts as a single entry. Reads and peeks on an empty
      // queue are refused, a second write to the full queue is refused
      // without overwrite, and a peek past the fill level is refused.
      write_settings(5'd0, 5'd0);
      pending_requests.push_back(make_op(OP_READ,  32'h1234_5678, 4'd0));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd0));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd15));
      pending_requests.push_back(make_op(OP_CLEAR, 32'h0,         4'd0));
      pending_requests.push_back(make_op(OP_WRITE, 32'h0000_0000, 4'd0));
      pending_requests.push_back(make_op(OP_WRITE, 32'hFFFF_FFFF, 4'd15));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd0));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd1));
      pending_requests.push_back(make_op(OP_READ,  32'h0,         4'd0));
      pending_requests.push_back(make_op(OP_READ,  32'h0,         4'd0));
      wait_drained();

      // Two entries with overwrite on: the third write drops the oldest
      // entry, and a clear leaves nothing to peek at.
      write_settings(5'd2, 5'd1);
      pending_requests.push_back(make_op(OP_WRITE, 32'hA5A5_5A5A, 4'd0));
      pending_requests.push_back(make_op(OP_WRITE, 32'h0000_0001, 4'd0));
      pending_requests.push_back(make_op(OP_WRITE, 32'h8000_0000, 4'd0));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd0));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd1));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd2));
      pending_requests.push_back(make_op(OP_READ,  32'h0,         4'd0));
      pending_requests.push_back(make_op(OP_CLEAR, 32'h0,         4'd0));
      pending_requests.push_back(make_op(OP_PEEK,  32'h0,         4'd0));
      wait_drained();

      // Random phases. Each one reprograms both registers while the block
      // is idle, which also clears the queue. The upper bits of the
      // overwrite value are random since only bit zero counts. The mix
      // swings between filling and draining after nineteen requests and then
      // every twenty, so that the queue keeps passing through full and empty.
      for (int ph = 0; ph < PHASES; ph++) begin
         write_settings(depth_list[ph], {4'($urandom_range(15)), overwrite_list[ph]});
         idle_percent = idle_list[ph];
         depth = clamp_depth(depth_list[ph]);
         filling = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 20 == 19) begin
               filling = !filling;
            end
            pending_requests.push_back(make_request(filling, depth));
         end
         wait_drained();
      end

      if (expected_responses.size() != 0) begin
         report_error("responses never delivered", expected_responses.size(), 32'd0);
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/rfo_pkg.sv
hdl/rfo_store.sv
hdl/rfo_ctrl.sv
hdl/ring_fifo_with_overwrite.sv
tb/ring_fifo_with_overwrite_tb.sv
